>>> hw/rtl/epse_pkg.sv
// Shared constants, codes and control types of the encoder period speed estimator.
package epse_pkg;

  // Speed scaling
  localparam int unsigned SPEED_NUMERATOR = 1000000;
  localparam int unsigned FRACTION_BITS   = 8;

  // Field widths
  localparam int TIME_W      = 32;
  localparam int SPEED_W     = 28;
  localparam int ALPHA_W     = 16;
  localparam int DEBOUNCE_W  = 16;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 2;

  // Divider sizing: the dividend is the scaled numerator, one quotient bit per step
  localparam logic [63:0] DIVIDEND = 64'(SPEED_NUMERATOR) << FRACTION_BITS;
  localparam int DIV_W = $clog2(DIVIDEND + 64'd1);
  localparam int CNT_W = (DIV_W > 1) ? $clog2(DIV_W) : 1;
  localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

  // Filter: weight is alpha or 1.0 - alpha, one extra bit for the full 1.0
  localparam int WEIGHT_W = ALPHA_W + 1;
  localparam int PROD_W   = WEIGHT_W + SPEED_W;
  localparam int ACC_W    = PROD_W + 1;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << ALPHA_W;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_LIMIT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STALL_TIMEOUT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_ALPHA   = 2'd2;

  // Register reset values
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd500;
  localparam logic [TIME_W-1:0]     STALL_RESET    = 32'd100000;
  localparam logic [ALPHA_W-1:0]    ALPHA_RESET    = 16'd52429;

  // Operation codes
  typedef enum logic {
    OP_EDGE = 1'b0,
    OP_READ = 1'b1
  } op_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_MUL_A,
    ST_MUL_B,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [DEBOUNCE_W-1:0] debounce_limit;
    logic [TIME_W-1:0]     stall_timeout;
    logic [ALPHA_W-1:0]    filter_alpha;
  } epse_cfg_t;

  typedef struct packed {
    logic latch_delta;
    logic edge_commit;
    logic div_start;
    logic div_step;
    logic stall_clear;
    logic mac_first;
    logic mac_second;
    logic out_load;
  } epse_cmd_t;

  typedef struct packed {
    logic stalled;
    logic period_zero;
    logic div_last;
    logic out_free;
  } epse_status_t;

endpackage

>>> hw/rtl/epse_ctrl.sv
// Controller state machine: sequences edge updates, speed reads and result hand-off.
module epse_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  operation,
  output logic                  in_stall,
  input  epse_pkg::epse_status_t status,
  output epse_pkg::epse_cmd_t    cmd
);
  import epse_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  // Input is open only in idle, so the accept follows the state directly
  assign accept = in_valid && state == ST_IDLE;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && operation == OP_READ) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.stalled) begin
          state_next = ST_DONE;
        end else if (status.period_zero) begin
          state_next = ST_MUL_A;
        end else begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (status.div_last) begin
          state_next = ST_MUL_A;
        end
      end
      ST_MUL_A: state_next = ST_MUL_B;
      ST_MUL_B: state_next = ST_DONE;
      ST_DONE: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall        = 1'b0;
        cmd.edge_commit = accept && operation == OP_EDGE;
        cmd.latch_delta = accept && operation == OP_READ;
      end
      ST_CHECK: begin
        cmd.stall_clear = status.stalled;
        cmd.div_start   = !status.stalled;
      end
      ST_DIVIDE: cmd.div_step   = 1'b1;
      ST_MUL_A:  cmd.mac_first  = 1'b1;
      ST_MUL_B:  cmd.mac_second = 1'b1;
      ST_DONE:   cmd.out_load   = status.out_free;
      default:   cmd = '0;
    endcase
  end

  // A taken read always goes through the timeout check next
  a_read_to_check: assert property (@(posedge clk) disable iff (rst)
    accept && operation == OP_READ |=> state == ST_CHECK)
    else $error("read transaction did not enter the timeout check");

  // A result is loaded only into a free output slot
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("result loaded over a waiting transaction");

  // After a divide run the filter always follows
  a_div_to_mul: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIVIDE && status.div_last |=> state == ST_MUL_A)
    else $error("divider finish not followed by filter");

endmodule

>>> hw/rtl/epse_dp.sv
// Datapath: edge timing state, serial divider, shared filter multiplier, result register.
module epse_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  epse_pkg::epse_cfg_t             cfg,
  input  logic [epse_pkg::TIME_W-1:0]     timestamp,
  input  epse_pkg::epse_cmd_t             cmd,
  output epse_pkg::epse_status_t          status,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [epse_pkg::SPEED_W-1:0]    filtered_speed
);
  import epse_pkg::*;

  localparam logic [DIV_W-1:0] DIVIDEND_V = DIVIDEND[DIV_W-1:0];

  logic [TIME_W-1:0]  last_edge_time;
  logic [TIME_W-1:0]  last_period;
  logic [SPEED_W-1:0] speed_estimate;
  logic [TIME_W-1:0]  delta_reg;
  logic [TIME_W-1:0]  divisor;
  logic [TIME_W-1:0]  rem;
  logic [DIV_W-1:0]   quot;
  logic [CNT_W-1:0]   cnt;
  logic [PROD_W-1:0]  acc;

  logic [TIME_W-1:0]   delta;
  logic [TIME_W-1:0]   period_max;
  logic                edge_ok;
  logic [TIME_W:0]     rem_shift;
  logic                rem_ge;
  logic [SPEED_W-1:0]  measured;
  logic [WEIGHT_W-1:0] mul_weight;
  logic [SPEED_W-1:0]  mul_value;
  logic [PROD_W-1:0]   prod;
  logic [ACC_W-1:0]    sum;

  // Interval since the last accepted edge, modulo 2^32
  assign delta      = timestamp - last_edge_time;
  assign edge_ok    = delta >= TIME_W'(cfg.debounce_limit);
  assign period_max = (delta_reg > last_period) ? delta_reg : last_period;

  // Restoring divide step
  assign rem_shift = {rem, DIVIDEND_V[cnt]};
  assign rem_ge    = rem_shift >= {1'b0, divisor};

  // Quotient clipped to the speed range
  assign measured = (64'(quot) > 64'(SPEED_MAX)) ? SPEED_MAX : SPEED_W'(quot);

  // Shared multiplier: alpha * estimate, then (1 - alpha) * measured
  assign mul_weight = cmd.mac_second ? (WEIGHT_ONE - WEIGHT_W'(cfg.filter_alpha))
                                     : WEIGHT_W'(cfg.filter_alpha);
  assign mul_value  = cmd.mac_second ? measured : speed_estimate;
  assign prod       = PROD_W'(mul_weight) * PROD_W'(mul_value);
  assign sum        = ACC_W'(acc) + ACC_W'(prod);

  // Status to the controller
  assign status.stalled     = delta_reg > cfg.stall_timeout;
  assign status.period_zero = period_max == '0;
  assign status.div_last    = cnt == '0;
  assign status.out_free    = !out_valid || !out_stall;

  // Edge timing and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge_time <= '0;
      last_period    <= '0;
      speed_estimate <= '0;
    end else begin
      if (cmd.edge_commit && edge_ok) begin
        last_period    <= delta;
        last_edge_time <= timestamp;
      end
      if (cmd.stall_clear) begin
        speed_estimate <= '0;
      end else if (cmd.mac_second) begin
        speed_estimate <= sum[ALPHA_W +: SPEED_W];
      end
    end
  end

  // Read interval, divider and accumulator
  always_ff @(posedge clk) begin
    if (cmd.latch_delta) begin
      delta_reg <= delta;
    end
    if (cmd.div_start) begin
      divisor <= period_max;
      rem     <= '0;
      quot    <= '0;
      cnt     <= CNT_W'(DIV_W - 1);
    end else if (cmd.div_step) begin
      rem  <= rem_ge ? TIME_W'(rem_shift - {1'b0, divisor}) : rem_shift[TIME_W-1:0];
      quot <= (quot << 1) | DIV_W'(rem_ge);
      cnt  <= cnt - CNT_W'(1);
    end
    if (cmd.mac_first) begin
      acc <= prod;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      filtered_speed <= speed_estimate;
    end
  end

  // The divider never runs on a zero period
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> divisor != '0)
    else $error("divide step with zero divisor");

  // A bounced edge leaves the edge time alone
  a_bounce_hold: assert property (@(posedge clk) disable iff (rst)
    cmd.edge_commit && !edge_ok |=> $stable(last_edge_time) && $stable(last_period))
    else $error("rejected edge changed the edge state");

endmodule

>>> hw/rtl/encoder_period_speed_estimator_core.sv
// Top level of the encoder period speed estimator: register file and controller/datapath.
// Each transaction is an encoder edge (operation 0) or a speed read (operation 1) with a
// 32-bit microsecond timestamp. An edge gives no result. A read gives one filtered_speed
// result: it latches the interval, does the timeout check and period choice, runs the
// serial restoring divider, then uses the shared filter multiplier for alpha times the
// old estimate and (1 - alpha) times the measured speed, and loads the output register;
// a read that hits the stall timeout skips divider and filter, and one with a zero
// period skips the divider. While a read is in progress in_stall is high. A result
// waiting in the output register does not hold off edges, only the hand-off of the next
// read. Registers are written through cfg_valid/cfg_ready (ready is always high) and
// should be changed only while the block is idle; writes to index 3 are ignored.
module encoder_period_speed_estimator_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              operation,
  input  logic [epse_pkg::TIME_W-1:0]        timestamp,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [epse_pkg::SPEED_W-1:0]       filtered_speed,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [epse_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [epse_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import epse_pkg::*;

  epse_cfg_t    cfg;
  epse_cmd_t    cmd;
  epse_status_t status;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_limit <= DEBOUNCE_RESET;
      cfg.stall_timeout  <= STALL_RESET;
      cfg.filter_alpha   <= ALPHA_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEBOUNCE_LIMIT: cfg.debounce_limit <= cfg_data[DEBOUNCE_W-1:0];
        CFG_STALL_TIMEOUT:  cfg.stall_timeout  <= cfg_data[TIME_W-1:0];
        CFG_FILTER_ALPHA:   cfg.filter_alpha   <= cfg_data[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  epse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .operation (operation),
    .in_stall  (in_stall),
    .status    (status),
    .cmd       (cmd)
  );

  epse_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .timestamp      (timestamp),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .filtered_speed (filtered_speed)
  );

endmodule
